// ===== hw/rtl/variable_step_verlet_integrator_macros.svh =====
// Assertion macros shared by the checker of the Verlet integrator.
// No dependencies; included by the files that carry assertions.
`ifndef VARIABLE_STEP_VERLET_INTEGRATOR_MACROS_SVH
`define VARIABLE_STEP_VERLET_INTEGRATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VSVI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VSVI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/vsvi_pkg.sv =====
// Shared types, constants and functions of the variable-step Verlet integrator.
// No dependencies; used by the factor unit, the axis pipeline and the top level.
`default_nettype none

package vsvi_pkg;

   // Value and step formats.
   localparam int VALUE_W   = 32;
   localparam int STEP_W    = 32;
   localparam int FACTOR_W  = 2 * STEP_W;
   localparam int HALF_W    = FACTOR_W / 2;
   localparam int AXES      = 3;
   localparam int STAGES    = 8;

   // Shift of the velocity product: 2 * (1/dt) with 1/dt carrying 31 fraction bits.
   localparam int RECIP_SHIFT = 30;

   // Stream widths: four input vectors, two result vectors.
   localparam int REQ_DATA_W = 4 * AXES * VALUE_W;
   localparam int RSP_DATA_W = 2 * AXES * VALUE_W;

   // Width used by the saturation helper; covers every pre-clamp sum.
   localparam int WIDE_W = 72;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_NOW    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_BEFORE = 1'd1;

   // Divider sizing.
   localparam int DIV_STEPS = FACTOR_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Reset value of both step registers and the factors that follow from it.
   localparam logic [STEP_W-1:0]   STEP_RESET  = 32'd429497;
   localparam logic [FACTOR_W-1:0] RATIO_RESET =
      (FACTOR_W'(STEP_RESET) << STEP_W) / FACTOR_W'(STEP_RESET);
   localparam logic [FACTOR_W-1:0] RECIP_RESET =
      (FACTOR_W'(1) << (FACTOR_W - 1)) / FACTOR_W'(STEP_RESET);
   localparam logic [FACTOR_W-1:0] HALF_RESET =
      ((FACTOR_W'(STEP_RESET) + FACTOR_W'(STEP_RESET)) * FACTOR_W'(STEP_RESET)) >> 1;

   // Clamp limits.
   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // Factor unit sequencer states.
   typedef enum logic [1:0] {
      FAC_IDLE,
      FAC_LOAD,
      FAC_RATIO,
      FAC_RECIP
   } fac_state_type;

   // Step-derived factors handed from the factor unit to the datapath.
   typedef struct packed {
      logic [FACTOR_W-1:0] ratio;      // dt/dt_old, Q32.32
      logic [FACTOR_W-1:0] recip;      // 1/dt, 31 fraction bits
      logic [FACTOR_W-1:0] half_span;  // 0.5*(dt+dt_old)*dt, units of 2^-64 s^2
      logic                step_zero;  // either step register is zero
      logic                busy;       // factors are being recomputed
   } factors_type;

   // Clamped value and its overflow flag.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               flag;
   } sat_type;

   // Clamp a wide signed value to the signed value range.
   function automatic sat_type saturate(input logic signed [WIDE_W-1:0] w);
      sat_type r;
      logic    fits;
      fits   = (&w[WIDE_W-1:VALUE_W-1]) || !(|w[WIDE_W-1:VALUE_W-1]);
      r.flag = !fits;
      if (fits) begin
         r.value = w[VALUE_W-1:0];
      end else if (w[WIDE_W-1]) begin
         r.value = VALUE_MIN;
      end else begin
         r.value = VALUE_MAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/variable_step_verlet_integrator.sv =====
// An accepted request item reaches rsp_tvalid after passing the eight axis pipeline stages.
// Throughput: one item per cycle unless a low rsp_tready or a busy factor unit holds the pipeline.
// Reset clears the pipeline and loads default step factors; req_tready rises at once.
// Each csr write reruns the factor unit (half span, then two 64-step restoring
// divisions), so req_tready stays low until the factor unit is idle again.
`default_nettype none

module variable_step_verlet_integrator (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // From bit 0: pos_x, pos_y, pos_z, prev_pos_x, prev_pos_y, prev_pos_z,
   // accel_x, accel_y, accel_z, vel_x, vel_y, vel_z, 32 bits each.
   input  logic [vsvi_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // From bit 0: next_pos_x, next_pos_y, next_pos_z,
   // next_vel_x, next_vel_y, next_vel_z, 32 bits each.
   output logic [vsvi_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Bit 0: range_flag.
   output logic                                rsp_tuser,
   // Configuration write port.
   input  logic                                csr_wen,
   input  logic [vsvi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vsvi_pkg::STEP_W-1:0]         csr_wdata
);

   localparam int VW = vsvi_pkg::VALUE_W;
   localparam int NA = vsvi_pkg::AXES;
   localparam int NS = vsvi_pkg::STAGES;

   vsvi_pkg::factors_type factors;

   logic [NS-1:0] valid_ff, valid_in;
   logic [NS-1:0] stage_en;
   logic          req_accept;

   logic signed [VW-1:0] next_pos [NA];
   logic signed [VW-1:0] next_vel [NA];
   logic [NA-1:0]        axis_flag;

   // Step registers and derived factors.
   vsvi_factors u_factors (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .factors   (factors)
   );

   // A stage advances when it is empty or the stage after it advances.
   always_comb begin
      stage_en[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      req_tready = stage_en[0] && !factors.busy;
      req_accept = req_tvalid && req_tready;
   end

   // Valid bits travel with the items.
   always_comb begin
      valid_in[0] = stage_en[0] ? req_accept : valid_ff[0];
      for (int i = 1; i < NS; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // One pipeline per axis.
   for (genvar k = 0; k < NA; k++) begin : g_axis
      vsvi_axis u_axis (
         .clock      (clock),
         .stage_en   (stage_en),
         .factors    (factors),
         .pos        ($signed(req_tdata[k*VW +: VW])),
         .prev_pos   ($signed(req_tdata[(NA+k)*VW +: VW])),
         .accel      ($signed(req_tdata[(2*NA+k)*VW +: VW])),
         .vel        ($signed(req_tdata[(3*NA+k)*VW +: VW])),
         .next_pos   (next_pos[k]),
         .next_vel   (next_vel[k]),
         .range_flag (axis_flag[k])
      );
   end

   // Result item packing.
   always_comb begin
      for (int k = 0; k < NA; k++) begin
         rsp_tdata[k*VW +: VW]      = next_pos[k];
         rsp_tdata[(NA+k)*VW +: VW] = next_vel[k];
      end
      rsp_tuser  = |axis_flag;
      rsp_tvalid = valid_ff[NS-1];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/vsvi_factors.sv =====
// Step registers and the sequencer that derives ratio, reciprocal and half span.
// Depends on vsvi_pkg; one restoring divider serves both divisions.
`default_nettype none

module vsvi_factors (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [vsvi_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [vsvi_pkg::STEP_W-1:0]           csr_wdata,
   output vsvi_pkg::factors_type                 factors
);

   localparam int SW     = vsvi_pkg::STEP_W;
   localparam int FW     = vsvi_pkg::FACTOR_W;
   localparam int CW     = vsvi_pkg::DIV_CNT_W;
   localparam int SPAN_W = 2 * SW + 1;

   vsvi_pkg::fac_state_type state_ff, state_in;

   logic [SW-1:0] step_now_ff, step_now_in;
   logic [SW-1:0] step_before_ff, step_before_in;
   logic [FW-1:0] ratio_ff, ratio_in;
   logic [FW-1:0] recip_ff, recip_in;
   logic [FW-1:0] half_ff, half_in;

   // Divider working registers.
   logic [SW-1:0] rem_ff, rem_in;
   logic [FW-1:0] quo_ff, quo_in;
   logic [FW-1:0] dvd_ff, dvd_in;
   logic [SW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] count_ff, count_in;

   logic [SW:0]       rem_shift;
   logic              sub_ok;
   logic [SW-1:0]     rem_next;
   logic [FW-1:0]     quo_next;
   logic [SW:0]       span_sum;
   logic [SPAN_W-1:0] span_prod;

   // Control and configuration state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= vsvi_pkg::FAC_IDLE;
         step_now_ff    <= vsvi_pkg::STEP_RESET;
         step_before_ff <= vsvi_pkg::STEP_RESET;
         ratio_ff       <= vsvi_pkg::RATIO_RESET;
         recip_ff       <= vsvi_pkg::RECIP_RESET;
         half_ff        <= vsvi_pkg::HALF_RESET;
      end else begin
         state_ff       <= state_in;
         step_now_ff    <= step_now_in;
         step_before_ff <= step_before_in;
         ratio_ff       <= ratio_in;
         recip_ff       <= recip_in;
         half_ff        <= half_in;
      end
   end

   // Divider data path needs no reset: every run loads it first.
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      count_ff <= count_in;
   end

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[FW-1]};
      sub_ok    = rem_shift >= {1'b0, dvs_ff};
      rem_next  = sub_ok ? SW'(rem_shift - {1'b0, dvs_ff}) : rem_shift[SW-1:0];
      quo_next  = {quo_ff[FW-2:0], sub_ok};
      span_sum  = {1'b0, step_now_ff} + {1'b0, step_before_ff};
      span_prod = SPAN_W'(span_sum) * SPAN_W'(step_now_ff);
   end

   // Sequencer: half span, then dt/dt_old, then 2^63/dt.
   always_comb begin
      state_in       = state_ff;
      step_now_in    = step_now_ff;
      step_before_in = step_before_ff;
      ratio_in       = ratio_ff;
      recip_in       = recip_ff;
      half_in        = half_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      dvd_in         = dvd_ff;
      dvs_in         = dvs_ff;
      count_in       = count_ff;

      case (state_ff)
         vsvi_pkg::FAC_IDLE: begin
         end
         vsvi_pkg::FAC_LOAD: begin
            half_in  = span_prod[SPAN_W-1:1];
            dvd_in   = {step_now_ff, {SW{1'b0}}};
            dvs_in   = step_before_ff;
            rem_in   = '0;
            count_in = '0;
            state_in = vsvi_pkg::FAC_RATIO;
         end
         vsvi_pkg::FAC_RATIO: begin
            rem_in   = rem_next;
            quo_in   = quo_next;
            dvd_in   = dvd_ff << 1;
            count_in = count_ff + CW'(1);
            if (count_ff == CW'(vsvi_pkg::DIV_STEPS - 1)) begin
               ratio_in = quo_next;
               dvd_in   = {1'b1, {(FW-1){1'b0}}};
               dvs_in   = step_now_ff;
               rem_in   = '0;
               count_in = '0;
               state_in = vsvi_pkg::FAC_RECIP;
            end
         end
         vsvi_pkg::FAC_RECIP: begin
            rem_in   = rem_next;
            quo_in   = quo_next;
            dvd_in   = dvd_ff << 1;
            count_in = count_ff + CW'(1);
            if (count_ff == CW'(vsvi_pkg::DIV_STEPS - 1)) begin
               recip_in = quo_next;
               state_in = vsvi_pkg::FAC_IDLE;
            end
         end
         default: begin
            state_in = vsvi_pkg::FAC_IDLE;
         end
      endcase

      // A register write restarts the whole derivation with the new value.
      if (csr_wen) begin
         case (csr_index)
            vsvi_pkg::REG_STEP_NOW: begin
               step_now_in = csr_wdata;
               state_in    = vsvi_pkg::FAC_LOAD;
            end
            vsvi_pkg::REG_STEP_BEFORE: begin
               step_before_in = csr_wdata;
               state_in       = vsvi_pkg::FAC_LOAD;
            end
            default: begin
            end
         endcase
      end
   end

   // Factor set seen by the datapath.
   always_comb begin
      factors.ratio     = ratio_ff;
      factors.recip     = recip_ff;
      factors.half_span = half_ff;
      factors.step_zero = (step_now_ff == '0) || (step_before_ff == '0);
      factors.busy      = state_ff != vsvi_pkg::FAC_IDLE;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/vsvi_axis.sv =====
// Eight-stage pipeline that integrates one axis: next position, then next velocity.
// Depends on vsvi_pkg; stage enables come from the top level, which keeps the valid bits.
`default_nettype none

module vsvi_axis (
   input  logic                                   clock,
   input  logic [vsvi_pkg::STAGES-1:0]            stage_en,
   input  vsvi_pkg::factors_type                  factors,
   input  logic signed [vsvi_pkg::VALUE_W-1:0]    pos,
   input  logic signed [vsvi_pkg::VALUE_W-1:0]    prev_pos,
   input  logic signed [vsvi_pkg::VALUE_W-1:0]    accel,
   input  logic signed [vsvi_pkg::VALUE_W-1:0]    vel,
   output logic signed [vsvi_pkg::VALUE_W-1:0]    next_pos,
   output logic signed [vsvi_pkg::VALUE_W-1:0]    next_vel,
   output logic                                   range_flag
);

   localparam int VW     = vsvi_pkg::VALUE_W;
   localparam int FW     = vsvi_pkg::FACTOR_W;
   localparam int HW     = vsvi_pkg::HALF_W;
   localparam int WW     = vsvi_pkg::WIDE_W;
   localparam int D_W    = VW + 1;
   localparam int PROD_W = D_W + HW + 1;
   localparam int T1_W   = PROD_W + 1;
   localparam int T2_W   = VW + 2;
   localparam int XS_W   = T1_W + 1;
   localparam int TV_W   = PROD_W + 2;
   localparam int VN_W   = TV_W + 1;

   // Stage 1: operands and position difference.
   logic signed [VW-1:0]  x1_ff, a1_ff, v1_ff;
   logic signed [D_W-1:0] d1_ff, d1_in;
   // Stage 2: partial products against the factor halves.
   logic signed [VW-1:0]     x2_ff, v2_ff;
   logic signed [PROD_W-1:0] pd_hi_ff, pd_hi_in, pd_lo_ff, pd_lo_in;
   logic signed [PROD_W-1:0] pa_hi_ff, pa_hi_in, pa_lo_ff, pa_lo_in;
   // Stage 3: floored product terms.
   logic signed [VW-1:0]   x3_ff, v3_ff;
   logic signed [T1_W-1:0] t1_ff, t1_in;
   logic signed [T2_W-1:0] t2_ff, t2_in;
   logic signed [T1_W-1:0] t2_wide, t2_shift;
   // Stage 4: unclamped next position.
   logic signed [VW-1:0]   x4_ff, v4_ff;
   logic signed [XS_W-1:0] xsum_ff, xsum_in;
   // Stage 5: clamped position and its displacement.
   vsvi_pkg::sat_type      sat_pos;
   logic signed [VW-1:0]   xn5_ff, v5_ff;
   logic signed [D_W-1:0]  m5_ff, m5_in;
   logic                   pf5_ff;
   // Stage 6: displacement times reciprocal, in halves.
   logic signed [VW-1:0]     xn6_ff, v6_ff;
   logic                     pf6_ff;
   logic signed [PROD_W-1:0] pm_hi_ff, pm_hi_in, pm_lo_ff, pm_lo_in;
   // Stage 7: velocity term before the subtraction.
   logic signed [VW-1:0]   xn7_ff, v7_ff;
   logic                   pf7_ff;
   logic signed [TV_W-1:0] tv_ff, tv_in;
   // Stage 8: output register.
   vsvi_pkg::sat_type      sat_vel;
   logic signed [VN_W-1:0] vn_diff;
   logic signed [VW-1:0]   next_pos_ff, next_pos_in, next_vel_ff, next_vel_in;
   logic                   flag_ff, flag_in;

   // Stage 1 and 2 logic.
   always_comb begin
      d1_in    = D_W'(pos) - D_W'(prev_pos);
      pd_hi_in = PROD_W'(d1_ff) * PROD_W'($signed({1'b0, factors.ratio[FW-1:HW]}));
      pd_lo_in = PROD_W'(d1_ff) * PROD_W'($signed({1'b0, factors.ratio[HW-1:0]}));
      pa_hi_in = PROD_W'(a1_ff) * PROD_W'($signed({1'b0, factors.half_span[FW-1:HW]}));
      pa_lo_in = PROD_W'(a1_ff) * PROD_W'($signed({1'b0, factors.half_span[HW-1:0]}));
   end

   // Stage 3 and 4 logic. The ratio has exactly HW fraction bits, so the
   // high partial product is already aligned; the half span has 2*HW.
   always_comb begin
      t1_in    = T1_W'(pd_hi_ff) + T1_W'(pd_lo_ff >>> HW);
      t2_wide  = T1_W'(pa_hi_ff) + T1_W'(pa_lo_ff >>> HW);
      t2_shift = t2_wide >>> HW;
      t2_in    = $signed(t2_shift[T2_W-1:0]);
      xsum_in  = XS_W'(x3_ff) + XS_W'(t1_ff) + XS_W'(t2_ff);
   end

   // Stage 5 and 6 logic. The velocity is taken from the clamped position.
   always_comb begin
      sat_pos  = vsvi_pkg::saturate(WW'(xsum_ff));
      m5_in    = D_W'($signed(sat_pos.value)) - D_W'(x4_ff);
      pm_hi_in = PROD_W'(m5_ff) * PROD_W'($signed({1'b0, factors.recip[FW-1:HW]}));
      pm_lo_in = PROD_W'(m5_ff) * PROD_W'($signed({1'b0, factors.recip[HW-1:0]}));
   end

   // Stage 7 and 8 logic; a zero step forces zeros and the flag.
   always_comb begin
      tv_in = (TV_W'(pm_hi_ff) <<< (HW - vsvi_pkg::RECIP_SHIFT))
            + TV_W'(pm_lo_ff >>> vsvi_pkg::RECIP_SHIFT);
      vn_diff = VN_W'(tv_ff) - VN_W'(v7_ff);
      sat_vel = vsvi_pkg::saturate(WW'(vn_diff));
      if (factors.step_zero) begin
         next_pos_in = '0;
         next_vel_in = '0;
         flag_in     = 1'b1;
      end else begin
         next_pos_in = xn7_ff;
         next_vel_in = $signed(sat_vel.value);
         flag_in     = pf7_ff || sat_vel.flag;
      end
   end

   // Pipeline registers; each stage holds while its enable is low.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x1_ff <= pos;
         d1_ff <= d1_in;
         a1_ff <= accel;
         v1_ff <= vel;
      end
      if (stage_en[1]) begin
         x2_ff    <= x1_ff;
         v2_ff    <= v1_ff;
         pd_hi_ff <= pd_hi_in;
         pd_lo_ff <= pd_lo_in;
         pa_hi_ff <= pa_hi_in;
         pa_lo_ff <= pa_lo_in;
      end
      if (stage_en[2]) begin
         x3_ff <= x2_ff;
         v3_ff <= v2_ff;
         t1_ff <= t1_in;
         t2_ff <= t2_in;
      end
      if (stage_en[3]) begin
         x4_ff   <= x3_ff;
         v4_ff   <= v3_ff;
         xsum_ff <= xsum_in;
      end
      if (stage_en[4]) begin
         xn5_ff <= $signed(sat_pos.value);
         m5_ff  <= m5_in;
         v5_ff  <= v4_ff;
         pf5_ff <= sat_pos.flag;
      end
      if (stage_en[5]) begin
         xn6_ff   <= xn5_ff;
         v6_ff    <= v5_ff;
         pf6_ff   <= pf5_ff;
         pm_hi_ff <= pm_hi_in;
         pm_lo_ff <= pm_lo_in;
      end
      if (stage_en[6]) begin
         xn7_ff <= xn6_ff;
         v7_ff  <= v6_ff;
         pf7_ff <= pf6_ff;
         tv_ff  <= tv_in;
      end
      if (stage_en[7]) begin
         next_pos_ff <= next_pos_in;
         next_vel_ff <= next_vel_in;
         flag_ff     <= flag_in;
      end
   end

   assign next_pos   = next_pos_ff;
   assign next_vel   = next_vel_ff;
   assign range_flag = flag_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/vsvi_checker.sv =====
// Port-level checks of the Verlet integrator, bound to its top level.
// Depends on vsvi_pkg and the shared assertion macro header.
`default_nettype none
`include "variable_step_verlet_integrator_macros.svh"

module vsvi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [vsvi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              csr_wen
);

   // A stalled result item stays offered and unchanged.
   `VSVI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result item withdrawn while stalled")
   `VSVI_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result item changed")

   // New step values block intake while the factors are recomputed.
   `VSVI_ASSERT_NEXT(a_cfg_block, clock, reset, csr_wen, !req_tready, "request taken before step factors were rebuilt")

   // Nothing comes out of a freshly reset pipeline.
   `VSVI_ASSERT_NOW(a_reset_empty, clock, reset, $fell(reset), !rsp_tvalid, "result item present right after reset")

endmodule

bind variable_step_verlet_integrator vsvi_checker u_vsvi_checker (.*);

`default_nettype wire
